/* design/dfr_pkg.sv */
// Shared types and constants for the delimited frame receiver.
// Used by every module of the block; depends on nothing else.

package dfr_pkg;

   localparam int DEF_BUF_LEN = 64;

   localparam int FUNC_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 6;
   localparam int EVENT_W = 3;
   localparam int LEN_W   = 6;

   // Item kinds on the request channel.
   localparam logic [FUNC_W-1:0] FUNC_BYTE    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

   // Event codes on the response channel.
   localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
   localparam logic [EVENT_W-1:0] EV_STORED = 3'd1;
   localparam logic [EVENT_W-1:0] EV_DONE   = 3'd2;
   localparam logic [EVENT_W-1:0] EV_BADTRL = 3'd3;
   localparam logic [EVENT_W-1:0] EV_OVFL   = 3'd4;

   // Delimiter characters.
   localparam logic [BYTE_W-1:0] CHAR_HEADER = 8'h40;  // '@'
   localparam logic [BYTE_W-1:0] CHAR_HASH   = 8'h23;  // '#'
   localparam logic [BYTE_W-1:0] CHAR_BANG   = 8'h21;  // '!'
   localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;

   typedef struct packed {
      logic [EVENT_W-1:0] event_res;
      logic               frame_ready;
      logic [LEN_W-1:0]   frame_length;
      logic               warn_flag;
      logic [BYTE_W-1:0]  read_data;
   } rsp_type;

endpackage

/* design/dfr_store.sv */
// Payload store of the frame receiver: one synchronous RAM with a
// registered read port and a clearing pass after reset. Uses dfr_pkg.

module dfr_store #(
   parameter int BUF_LEN = dfr_pkg::DEF_BUF_LEN,
   parameter int AW      = $clog2(BUF_LEN)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [dfr_pkg::BYTE_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [dfr_pkg::BYTE_W-1:0] rd_data,
   output logic                      clear_busy
);

   logic [dfr_pkg::BYTE_W-1:0] payload_mem [BUF_LEN];
   logic [dfr_pkg::BYTE_W-1:0] rd_data_ff;
   logic                       clearing_ff;
   logic                       clearing_in;
   logic [AW-1:0]              clr_addr_ff;
   logic [AW-1:0]              clr_addr_in;
   logic                       mem_we;
   logic [AW-1:0]              mem_addr;
   logic [dfr_pkg::BYTE_W-1:0] mem_data;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(BUF_LEN - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // The clearing pass owns the write port; no item is taken meanwhile.
   assign mem_we   = clearing_ff | wr_en;
   assign mem_addr = clearing_ff ? clr_addr_ff : wr_addr;
   assign mem_data = clearing_ff ? dfr_pkg::CHAR_NUL : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         payload_mem[mem_addr] <= mem_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= payload_mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clearing_ff;

endmodule

/* design/dfr_ctrl.sv */
// Framing state machine of the frame receiver: phase, fill count, ready and
// warning bits, and the store accesses each item causes. Uses dfr_pkg.

module dfr_ctrl #(
   parameter int BUF_LEN = dfr_pkg::DEF_BUF_LEN,
   parameter int AW      = $clog2(BUF_LEN)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [dfr_pkg::FUNC_W-1:0]  func,
   input  logic [dfr_pkg::BYTE_W-1:0]  rx_byte,
   input  logic [dfr_pkg::INDEX_W-1:0] read_index,
   output logic                        wr_en,
   output logic [AW-1:0]               wr_addr,
   output logic [dfr_pkg::BYTE_W-1:0]  wr_data,
   output logic                        rd_en,
   output logic [AW-1:0]               rd_addr,
   output dfr_pkg::rsp_type            status
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DATA = 2'd1;
   localparam logic [1:0] PH_EXCL = 2'd2;

   logic [1:0]                 phase_ff, phase_in;
   logic [AW-1:0]              fill_ff, fill_in;
   logic                       ready_ff, ready_in;
   logic                       warn_ff, warn_in;
   logic [AW-1:0]              done_len_ff, done_len_in;
   logic [dfr_pkg::EVENT_W-1:0] event_val;
   logic                       index_ok;

   assign index_ok = int'(read_index) < BUF_LEN;

   always_comb begin
      phase_in    = phase_ff;
      fill_in     = fill_ff;
      ready_in    = ready_ff;
      warn_in     = warn_ff;
      done_len_in = done_len_ff;
      event_val   = dfr_pkg::EV_NONE;
      wr_en       = 1'b0;
      wr_addr     = fill_ff;
      wr_data     = dfr_pkg::CHAR_NUL;
      rd_en       = 1'b0;
      if (accept) begin
         case (func)
            dfr_pkg::FUNC_BYTE: begin
               case (phase_ff)
                  PH_IDLE: begin
                     // A new header is refused while a finished frame waits.
                     if (rx_byte == dfr_pkg::CHAR_HEADER && !ready_ff) begin
                        phase_in = PH_DATA;
                        fill_in  = '0;
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                     end
                  end
                  PH_DATA: begin
                     if (rx_byte == dfr_pkg::CHAR_HASH) begin
                        phase_in = PH_EXCL;
                     end else if (fill_ff != AW'(BUF_LEN - 1)) begin
                        wr_en     = 1'b1;
                        wr_data   = rx_byte;
                        fill_in   = fill_ff + AW'(1);
                        event_val = dfr_pkg::EV_STORED;
                     end else begin
                        phase_in  = PH_IDLE;
                        fill_in   = '0;
                        event_val = dfr_pkg::EV_OVFL;
                     end
                  end
                  PH_EXCL: begin
                     if (rx_byte == dfr_pkg::CHAR_BANG) begin
                        wr_en       = 1'b1;
                        done_len_in = fill_ff;
                        ready_in    = 1'b1;
                        event_val   = dfr_pkg::EV_DONE;
                     end else begin
                        warn_in   = 1'b1;
                        event_val = dfr_pkg::EV_BADTRL;
                     end
                     phase_in = PH_IDLE;
                     fill_in  = '0;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     fill_in  = '0;
                  end
               endcase
            end
            dfr_pkg::FUNC_RELEASE: begin
               ready_in = 1'b0;
               warn_in  = 1'b0;
            end
            dfr_pkg::FUNC_READ: begin
               rd_en = index_ok;
            end
            default: begin
            end
         endcase
      end
   end

   assign rd_addr = AW'(read_index);

   always_comb begin
      status              = '0;
      status.event_res    = event_val;
      status.frame_ready  = ready_in;
      status.frame_length = dfr_pkg::LEN_W'(done_len_in);
      status.warn_flag    = warn_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         fill_ff     <= '0;
         ready_ff    <= 1'b0;
         warn_ff     <= 1'b0;
         done_len_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         fill_ff     <= fill_in;
         ready_ff    <= ready_in;
         warn_ff     <= warn_in;
         done_len_ff <= done_len_in;
      end
   end

endmodule

/* design/dfr_outreg.sv */
// Response register of the frame receiver: holds one finished result and
// presents it on the response stream. Uses dfr_pkg.

module dfr_outreg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load_valid,
   input  dfr_pkg::rsp_type load_data,
   output logic             load_ready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,
   output logic [2:0]       rsp_tuser
);

   logic             valid_ff, valid_in;
   dfr_pkg::rsp_type data_ff;

   assign load_ready = !valid_ff || rsp_tready;
   assign valid_in   = load_valid || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         data_ff <= load_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = data_ff.event_res;
   assign rsp_tdata  = {data_ff.read_data, data_ff.warn_flag, data_ff.frame_length,
                        data_ff.frame_ready};

endmodule

/* design/delimited_frame_receiver.sv */
// Top level of the delimited frame receiver: framing control, payload RAM
// and response register. Uses dfr_pkg, dfr_ctrl, dfr_store and dfr_outreg.
//
// Usage: each request transfer carries one item: a received serial byte,
// a release of the finished frame (which also clears the warning), or a
// read of one stored payload byte. Frames have the form '@' payload '#!'.
// Every request transfer yields exactly one response transfer with the
// event code, the ready and warning bits, the recorded frame length and,
// for a read, the stored byte.
// A request transfer passes the RAM read stage and then the response
// register before its response is offered. Throughput is one item per
// cycle while the response side does not stall; the RAM takes at most one
// access per item. After reset the payload RAM is cleared, one entry per
// cycle; req_tready stays low until that pass ends. When the response
// side stalls, the item in the RAM read stage waits and req_tready drops
// as soon as both the read stage and the response register are full.

module delimited_frame_receiver #(
   parameter int BUF_LEN = dfr_pkg::DEF_BUF_LEN
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // rx_byte [7:0], read_index [13:8], zero [15:14]
   input  logic [1:0]  req_tuser,  // func [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // frame_ready [0], frame_length [6:1], warn_flag [7],
                                   // read_data [15:8]
   output logic [2:0]  rsp_tuser   // event_res [2:0]
);

   localparam int AW = $clog2(BUF_LEN);

   logic                       accept;
   logic                       clear_busy;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [dfr_pkg::BYTE_W-1:0] wr_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [dfr_pkg::BYTE_W-1:0] rd_data;
   dfr_pkg::rsp_type           status;
   dfr_pkg::rsp_type           load_data;
   logic                       load_ready;

   logic             s1_valid_ff, s1_valid_in;
   dfr_pkg::rsp_type s1_stat_ff;
   logic             s1_rd_ff;

   assign req_tready  = !clear_busy && (!s1_valid_ff || load_ready);
   assign accept      = req_tvalid && req_tready;
   assign s1_valid_in = accept || (s1_valid_ff && !load_ready);

   dfr_ctrl #(
      .BUF_LEN (BUF_LEN),
      .AW      (AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .func       (req_tuser),
      .rx_byte    (req_tdata[7:0]),
      .read_index (req_tdata[13:8]),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .status     (status)
   );

   dfr_store #(
      .BUF_LEN (BUF_LEN),
      .AW      (AW)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .clear_busy (clear_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // The RAM read data register only changes on a new read, so it holds
   // while this stage waits for the response register.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stat_ff <= status;
         s1_rd_ff   <= rd_en;
      end
   end

   always_comb begin
      load_data           = s1_stat_ff;
      load_data.read_data = s1_rd_ff ? rd_data : dfr_pkg::CHAR_NUL;
   end

   dfr_outreg u_outreg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s1_valid_ff),
      .load_data  (load_data),
      .load_ready (load_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
